// ===== rtl/core/ptsl_pkg.sv =====
// ----------------------------------------------------------------------------
// ptsl_pkg: shared types and constants
// Configuration register indexes, gain and weight formats, and the command
// and status words passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package ptsl_pkg;

  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 17;
  localparam int OUT_TDW  = 80;

  localparam logic [CFG_AW-1:0] CFG_MODE        = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_KP          = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_KI          = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_KD          = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_ACC_PRESENT = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_ACC_PAST    = 3'd5;

  localparam logic [1:0] MODE_P   = 2'd0;
  localparam logic [1:0] MODE_PD  = 2'd1;
  localparam logic [1:0] MODE_PID = 2'd2;

  localparam logic [16:0] ACC_ONE = 17'h10000;

  typedef struct packed {
    logic [1:0]          mode;
    logic signed [15:0]  kp;
    logic signed [15:0]  ki;
    logic signed [15:0]  kd;
    logic [16:0]         acc_present;
    logic [16:0]         acc_past;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_KP_ERR,
    MUL_KD_DIFF,
    MUL_ERR_ACCP,
    MUL_INT_ACCP,
    MUL_KI_INT,
    MUL_SQ
  } mul_e;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_P_SET,
    ACC_D_ADD,
    ACC_T_SET,
    ACC_T_ADD,
    ACC_I_ADD,
    ACC_N_SET,
    ACC_N_ADD
  } acc_e;

  typedef struct packed {
    logic  in_load;
    logic  clr;
    mul_e  mul;
    logic  mul_ax;
    acc_e  acc;
    logic  acc_ax;
    logic  int_upd;
    logic  int_ax;
    logic  fin;
    logic  fin_ax;
    logic  sq_init;
    logic  sq_step;
    logic  spd_fin;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic n_big;
  } sts_t;

endpackage

// ===== rtl/core/ptsl_cfg.sv =====
// ----------------------------------------------------------------------------
// ptsl_cfg: configuration registers
// Holds mode, gains and integrator weights; weights above one are clamped.
// ----------------------------------------------------------------------------
module ptsl_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ptsl_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [ptsl_pkg::CFG_DW-1:0]  cfg_wdata_i,
  output ptsl_pkg::cfg_t               cfg_o
);

  ptsl_pkg::cfg_t cfg_q, cfg_d;

  function automatic logic [16:0] clamp_acc(input logic [16:0] v);
    return (v > ptsl_pkg::ACC_ONE) ? ptsl_pkg::ACC_ONE : v;
  endfunction

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        ptsl_pkg::CFG_MODE:        cfg_d.mode        = cfg_wdata_i[1:0];
        ptsl_pkg::CFG_KP:          cfg_d.kp          = $signed(cfg_wdata_i[15:0]);
        ptsl_pkg::CFG_KI:          cfg_d.ki          = $signed(cfg_wdata_i[15:0]);
        ptsl_pkg::CFG_KD:          cfg_d.kd          = $signed(cfg_wdata_i[15:0]);
        ptsl_pkg::CFG_ACC_PRESENT: cfg_d.acc_present = clamp_acc(cfg_wdata_i[16:0]);
        ptsl_pkg::CFG_ACC_PAST:    cfg_d.acc_past    = clamp_acc(cfg_wdata_i[16:0]);
        default:                   cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode        <= ptsl_pkg::MODE_PID;
      cfg_q.kp          <= '0;
      cfg_q.ki          <= '0;
      cfg_q.kd          <= '0;
      cfg_q.acc_present <= ptsl_pkg::ACC_ONE;
      cfg_q.acc_past    <= ptsl_pkg::ACC_ONE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/ptsl_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptsl_ctrl: sequencer
// Steps the shared multiplier schedule, the square root iterations and the
// output register handshake.
// ----------------------------------------------------------------------------
module ptsl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_clr_i,
  input  logic             out_ready_i,
  input  ptsl_pkg::sts_t   sts_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output ptsl_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_SQ_INIT,
    ST_SQRT,
    ST_FIN,
    ST_OUT
  } state_e;

  localparam logic [3:0] LAST_STEP = 4'd14;
  localparam logic [3:0] LAST_ITER = 4'd15;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;

  function automatic ptsl_pkg::cmd_t step_cmd(input logic [3:0] step);
    ptsl_pkg::cmd_t c;
    c = '0;
    case (step)
      4'd0: begin
        c.mul = ptsl_pkg::MUL_KP_ERR;   c.mul_ax = 1'b0;
      end
      4'd1: begin
        c.mul = ptsl_pkg::MUL_KP_ERR;   c.mul_ax = 1'b1;
        c.acc = ptsl_pkg::ACC_P_SET;    c.acc_ax = 1'b0;
      end
      4'd2: begin
        c.mul = ptsl_pkg::MUL_KD_DIFF;  c.mul_ax = 1'b0;
        c.acc = ptsl_pkg::ACC_P_SET;    c.acc_ax = 1'b1;
      end
      4'd3: begin
        c.mul = ptsl_pkg::MUL_KD_DIFF;  c.mul_ax = 1'b1;
        c.acc = ptsl_pkg::ACC_D_ADD;    c.acc_ax = 1'b0;
      end
      4'd4: begin
        c.mul = ptsl_pkg::MUL_ERR_ACCP; c.mul_ax = 1'b0;
        c.acc = ptsl_pkg::ACC_D_ADD;    c.acc_ax = 1'b1;
      end
      4'd5: begin
        c.mul = ptsl_pkg::MUL_ERR_ACCP; c.mul_ax = 1'b1;
        c.acc = ptsl_pkg::ACC_T_SET;    c.acc_ax = 1'b0;
      end
      4'd6: begin
        c.mul = ptsl_pkg::MUL_INT_ACCP; c.mul_ax = 1'b0;
        c.acc = ptsl_pkg::ACC_T_SET;    c.acc_ax = 1'b1;
      end
      4'd7: begin
        c.mul = ptsl_pkg::MUL_INT_ACCP; c.mul_ax = 1'b1;
        c.acc = ptsl_pkg::ACC_T_ADD;    c.acc_ax = 1'b0;
      end
      4'd8: begin
        c.acc = ptsl_pkg::ACC_T_ADD;    c.acc_ax = 1'b1;
        c.int_upd = 1'b1;               c.int_ax = 1'b0;
      end
      4'd9: begin
        c.mul = ptsl_pkg::MUL_KI_INT;   c.mul_ax = 1'b0;
        c.int_upd = 1'b1;               c.int_ax = 1'b1;
      end
      4'd10: begin
        c.mul = ptsl_pkg::MUL_KI_INT;   c.mul_ax = 1'b1;
        c.acc = ptsl_pkg::ACC_I_ADD;    c.acc_ax = 1'b0;
      end
      4'd11: begin
        c.acc = ptsl_pkg::ACC_I_ADD;    c.acc_ax = 1'b1;
        c.fin = 1'b1;                   c.fin_ax = 1'b0;
      end
      4'd12: begin
        c.mul = ptsl_pkg::MUL_SQ;       c.mul_ax = 1'b0;
        c.fin = 1'b1;                   c.fin_ax = 1'b1;
      end
      4'd13: begin
        c.mul = ptsl_pkg::MUL_SQ;       c.mul_ax = 1'b1;
        c.acc = ptsl_pkg::ACC_N_SET;
      end
      4'd14: begin
        c.acc = ptsl_pkg::ACC_N_ADD;
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_clr_i) begin
            cmd_o.clr = 1'b1;
            state_d   = ST_OUT;
          end else begin
            cmd_o.in_load = 1'b1;
            cnt_d         = '0;
            state_d       = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd_o = step_cmd(cnt_q);
        if (cnt_q == LAST_STEP) begin
          state_d = ST_SQ_INIT;
        end else begin
          cnt_d = 4'(cnt_q + 4'd1);
        end
      end
      ST_SQ_INIT: begin
        cmd_o.sq_init = 1'b1;
        cnt_d         = '0;
        state_d       = sts_i.n_big ? ST_FIN : ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sq_step = 1'b1;
        if (cnt_q == LAST_ITER) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = 4'(cnt_q + 4'd1);
        end
      end
      ST_FIN: begin
        cmd_o.spd_fin = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = cmd_o.out_load | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/ptsl_dp.sv =====
// ----------------------------------------------------------------------------
// ptsl_dp: datapath
// Error registers, one shared signed multiplier, term accumulators, leaky
// integrators, saturation, restoring square root and the output register.
// ----------------------------------------------------------------------------
module ptsl_dp #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptsl_pkg::cmd_t                cmd_i,
  input  ptsl_pkg::cfg_t                cfg_i,
  input  logic signed [DATA_WIDTH-1:0]  setpoint_x_i,
  input  logic signed [DATA_WIDTH-1:0]  measured_x_i,
  input  logic signed [DATA_WIDTH-1:0]  setpoint_y_i,
  input  logic signed [DATA_WIDTH-1:0]  measured_y_i,
  input  logic [15:0]                   max_speed_i,
  output ptsl_pkg::sts_t                sts_o,
  output logic signed [31:0]            corr_x_o,
  output logic signed [31:0]            corr_y_o,
  output logic [15:0]                   speed_o
);

  localparam int EW  = DATA_WIDTH + 1;
  localparam int DFW = DATA_WIDTH + 2;
  localparam int AW  = (DATA_WIDTH + 2 > 33) ? DATA_WIDTH + 2 : 33;
  localparam int BW  = 33;
  localparam int PW  = AW + BW;
  localparam int SW  = (DATA_WIDTH + 12 > 42) ? DATA_WIDTH + 12 : 42;
  localparam int TW  = (DATA_WIDTH + 20 > 51) ? DATA_WIDTH + 20 : 51;

  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  logic signed [EW-1:0]  err_x_q, err_y_q, prev_x_q, prev_y_q;
  logic signed [DFW-1:0] diff_x_q, diff_y_q;
  logic signed [31:0]    integ_x_q, integ_y_q, corr_x_q, corr_y_q;
  logic signed [SW-1:0]  sum_x_q, sum_y_q;
  logic signed [TW-1:0]  tmp_x_q, tmp_y_q;
  logic signed [PW-1:0]  prod_q, prod_d, term8;
  logic [63:0]           n_q;
  logic [31:0]           rad_q;
  logic [16:0]           rem_q;
  logic [15:0]           root_q, maxs_q, speed_q;
  logic signed [31:0]    out_cx_q, out_cy_q;
  logic [15:0]           out_spd_q;

  logic signed [AW-1:0]  a_op;
  logic signed [BW-1:0]  b_op;
  logic signed [EW-1:0]  err_m;
  logic signed [DFW-1:0] diff_m;
  logic signed [31:0]    integ_m, corr_m;
  logic [31:0]           mag;
  logic signed [SW-1:0]  term_s;
  logic signed [TW-1:0]  prod_t, tmp_i, sh16;
  logic signed [SW-1:0]  sum_f;
  logic signed [31:0]    int_new, sum_sat;
  logic [63:0]           prod_n;
  logic                  d_en, i_en, n_big;
  logic [18:0]           rem_nx, trial, rem_sub;
  logic                  ge;
  logic [15:0]           spd_new;

  assign d_en = (cfg_i.mode != ptsl_pkg::MODE_P) && (cfg_i.kd != '0);
  assign i_en = (cfg_i.mode >= ptsl_pkg::MODE_PID) && (cfg_i.ki != '0);

  assign err_m   = cmd_i.mul_ax ? err_y_q   : err_x_q;
  assign diff_m  = cmd_i.mul_ax ? diff_y_q  : diff_x_q;
  assign integ_m = cmd_i.mul_ax ? integ_y_q : integ_x_q;
  assign corr_m  = cmd_i.mul_ax ? corr_y_q  : corr_x_q;
  assign mag     = corr_m[31] ? 32'(~corr_m + 32'sd1) : corr_m;

  always_comb begin
    case (cmd_i.mul)
      ptsl_pkg::MUL_KP_ERR: begin
        a_op = AW'(err_m);
        b_op = BW'(cfg_i.kp);
      end
      ptsl_pkg::MUL_KD_DIFF: begin
        a_op = AW'(diff_m);
        b_op = BW'(cfg_i.kd);
      end
      ptsl_pkg::MUL_ERR_ACCP: begin
        a_op = AW'(err_m);
        b_op = BW'($signed({1'b0, cfg_i.acc_present}));
      end
      ptsl_pkg::MUL_INT_ACCP: begin
        a_op = AW'(integ_m);
        b_op = BW'($signed({1'b0, cfg_i.acc_past}));
      end
      ptsl_pkg::MUL_KI_INT: begin
        a_op = AW'(integ_m);
        b_op = BW'(cfg_i.ki);
      end
      ptsl_pkg::MUL_SQ: begin
        a_op = AW'($signed({1'b0, mag}));
        b_op = $signed({1'b0, mag});
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign prod_d = a_op * b_op;
  assign term8  = prod_q >>> 8;
  assign term_s = $signed(term8[SW-1:0]);
  assign prod_t = $signed(prod_q[TW-1:0]);
  assign prod_n = prod_q[63:0];

  assign tmp_i   = cmd_i.int_ax ? tmp_y_q : tmp_x_q;
  assign sh16    = tmp_i >>> 16;
  assign int_new = ((&sh16[TW-1:31]) || !(|sh16[TW-1:31])) ? sh16[31:0]
                 : (sh16[TW-1] ? S32_MIN : S32_MAX);

  assign sum_f   = cmd_i.fin_ax ? sum_y_q : sum_x_q;
  assign sum_sat = ((&sum_f[SW-1:31]) || !(|sum_f[SW-1:31])) ? sum_f[31:0]
                 : (sum_f[SW-1] ? S32_MIN : S32_MAX);

  assign n_big   = |n_q[63:32];
  assign rem_nx  = {rem_q, rad_q[31:30]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign ge      = (rem_nx >= trial);
  assign rem_sub = rem_nx - trial;
  assign spd_new = n_big ? maxs_q : ((root_q > maxs_q) ? maxs_q : root_q);

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    diff_x_q <= DFW'(err_x_q) - DFW'(prev_x_q);
    diff_y_q <= DFW'(err_y_q) - DFW'(prev_y_q);
    if (cmd_i.in_load) begin
      err_x_q <= EW'(setpoint_x_i) - EW'(measured_x_i);
      err_y_q <= EW'(setpoint_y_i) - EW'(measured_y_i);
      maxs_q  <= max_speed_i;
    end
    case (cmd_i.acc)
      ptsl_pkg::ACC_P_SET: begin
        if (cmd_i.acc_ax) sum_y_q <= term_s;
        else              sum_x_q <= term_s;
      end
      ptsl_pkg::ACC_D_ADD: begin
        if (d_en) begin
          if (cmd_i.acc_ax) sum_y_q <= sum_y_q + term_s;
          else              sum_x_q <= sum_x_q + term_s;
        end
      end
      ptsl_pkg::ACC_T_SET: begin
        if (cmd_i.acc_ax) tmp_y_q <= prod_t;
        else              tmp_x_q <= prod_t;
      end
      ptsl_pkg::ACC_T_ADD: begin
        if (cmd_i.acc_ax) tmp_y_q <= tmp_y_q + prod_t;
        else              tmp_x_q <= tmp_x_q + prod_t;
      end
      ptsl_pkg::ACC_I_ADD: begin
        if (i_en) begin
          if (cmd_i.acc_ax) sum_y_q <= sum_y_q + term_s;
          else              sum_x_q <= sum_x_q + term_s;
        end
      end
      ptsl_pkg::ACC_N_SET: n_q <= prod_n;
      ptsl_pkg::ACC_N_ADD: n_q <= n_q + prod_n;
      default: ;
    endcase
    if (cmd_i.sq_init) begin
      rad_q  <= n_q[31:0];
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sq_step) begin
      rem_q  <= ge ? rem_sub[16:0] : rem_nx[16:0];
      root_q <= {root_q[14:0], ge};
      rad_q  <= {rad_q[29:0], 2'b00};
    end
    if (cmd_i.out_load) begin
      out_cx_q  <= corr_x_q;
      out_cy_q  <= corr_y_q;
      out_spd_q <= speed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      integ_x_q <= '0;
      integ_y_q <= '0;
      corr_x_q  <= '0;
      corr_y_q  <= '0;
      speed_q   <= '0;
    end else if (cmd_i.clr) begin
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      integ_x_q <= '0;
      integ_y_q <= '0;
      corr_x_q  <= '0;
      corr_y_q  <= '0;
      speed_q   <= '0;
    end else begin
      if (cmd_i.int_upd && i_en) begin
        if (cmd_i.int_ax) integ_y_q <= int_new;
        else              integ_x_q <= int_new;
      end
      if (cmd_i.fin) begin
        if (cmd_i.fin_ax) begin
          corr_y_q <= sum_sat;
          prev_y_q <= err_y_q;
        end else begin
          corr_x_q <= sum_sat;
          prev_x_q <= err_x_q;
        end
      end
      if (cmd_i.spd_fin) begin
        speed_q <= spd_new;
      end
    end
  end

  assign sts_o.n_big = n_big;
  assign corr_x_o    = out_cx_q;
  assign corr_y_o    = out_cy_q;
  assign speed_o     = out_spd_q;

endmodule

// ===== rtl/core/pid_two_axis_speed_limit_top.sv =====
// ----------------------------------------------------------------------------
// pid_two_axis_speed_limit_top: two-axis PID with leaky integrator
// Shared-gain PID on X and Y with saturated corrections and a speed
// magnitude clamped to a per-word limit.
//
//   Channel   Direction  Contents
//   s_axis    in         tuser: cmd; tdata: setpoints, measurements, max_speed
//   m_axis    out        tdata: corr_x, corr_y, speed
//   cfg       in         write enable, register index, write data
//
// A compute word's result turns valid after fifteen steps on the one shared
// multiplier and the square root iterations; when the magnitude reaches 65536
// the square root is skipped. A clear word zeroes the stored state and goes
// straight to the output load. A finished result waits in the output register
// while the next word is accepted, which can happen from the cycle after the
// load; no word is taken before the last one's result is loaded. Reset zeroes
// the integrators, corrections, speed and stored errors and restores the registers to their defaults.
// ----------------------------------------------------------------------------
module pid_two_axis_speed_limit_top #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [ptsl_pkg::CFG_AW-1:0]               cfg_addr_i,
  input  logic [ptsl_pkg::CFG_DW-1:0]               cfg_wdata_i,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // setpoint_x, measured_x, setpoint_y, measured_y, max_speed, zero fill
  input  logic [((4*DATA_WIDTH+16+7)/8)*8-1:0]      s_axis_tdata,
  // cmd
  input  logic                                      s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // corr_x, corr_y, speed
  output logic [ptsl_pkg::OUT_TDW-1:0]              m_axis_tdata
);

  ptsl_pkg::cfg_t cfg;
  ptsl_pkg::cmd_t cmd;
  ptsl_pkg::sts_t sts;

  logic signed [31:0] corr_x, corr_y;
  logic [15:0]        speed;

  ptsl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ptsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_clr_i    (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  ptsl_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_i        (cfg),
    .setpoint_x_i ($signed(s_axis_tdata[DATA_WIDTH-1:0])),
    .measured_x_i ($signed(s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH])),
    .setpoint_y_i ($signed(s_axis_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH])),
    .measured_y_i ($signed(s_axis_tdata[4*DATA_WIDTH-1:3*DATA_WIDTH])),
    .max_speed_i  (s_axis_tdata[4*DATA_WIDTH+15:4*DATA_WIDTH]),
    .sts_o        (sts),
    .corr_x_o     (corr_x),
    .corr_y_o     (corr_y),
    .speed_o      (speed)
  );

  assign m_axis_tdata = {speed, corr_y, corr_x};

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted again right after a word was taken");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register loaded over a pending result");

  a_weights_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg.acc_present <= ptsl_pkg::ACC_ONE) && (cfg.acc_past <= ptsl_pkg::ACC_ONE))
    else $error("integrator weight above one");

endmodule
